### hdl/tangent_plane_uv_projection_assert.svh
// ----------------------------------------------------------------------------
// Tangent plane UV projection: assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TANGENT_PLANE_UV_PROJECTION_ASSERT_SVH
`define TANGENT_PLANE_UV_PROJECTION_ASSERT_SVH

// same-cycle implication
`define TPUV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpuv assertion failed");

// next-cycle implication
`define TPUV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpuv assertion failed");

`endif

### hdl/tpuv_pkg.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection: package
// Field widths, internal datapath widths, pipeline geometry and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tpuv_pkg;

    localparam int POS_W   = 32;
    localparam int NORM_W  = 16;
    localparam int THR_W   = 15;
    localparam int COORD_W = 32;

    localparam logic [THR_W-1:0] THR_RESET = 15'd14205;   // 0.867 in Q1.14

    // internal widths
    localparam int T_W    = NORM_W + 1;   // tangent component, holds +32768
    localparam int D_W    = 36;           // p.n rounded to Q.16
    localparam int W_W    = 38;           // projected position
    localparam int B_W    = 19;           // second tangent, Q.14
    localparam int TU_W   = 57;           // w.t
    localparam int TV_W   = 59;           // w.b
    localparam int LEN2_W = 32;           // |t|^2
    localparam int LEN_W  = 24;           // |t| in Q.22

    localparam int FRAC_SH  = 14;
    localparam int SQ_SHIFT = 16;         // len2 scaling before root
    localparam int UV_SHIFT = 8;          // numerator scaling before divide

    // pipeline geometry
    localparam int SQ_STEPS = 3;
    localparam int SQ_ST    = LEN_W / SQ_STEPS;
    localparam int DV_STEPS = 4;
    localparam int DV_ST    = COORD_W / DV_STEPS;

    localparam int FR_LEN2_STG = 2;       // front stage that registers len2
    localparam int FR_TUV_STG  = 6;       // front stage that registers tu/tv
    localparam int TUV_DLY     = FR_LEN2_STG + SQ_ST - FR_TUV_STG;
    localparam int DEG_DLY     = DV_ST + 1;
    localparam int LAT         = FR_LEN2_STG + SQ_ST + DV_ST + 2;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               sat;
    } clip_t;

    // round to nearest, ties away from zero, shift right by FRAC_SH
    function automatic logic signed [63:0] rnd_shr14(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? 64'(-x) : 64'(x);
        q = (mag + (64'd1 << (FRAC_SH - 1))) >> FRAC_SH;
        rnd_shr14 = x[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

### hdl/tpuv_front.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection: front datapath
// Plane projection, tangent pair and the two dot products (6 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module tpuv_front import tpuv_pkg::*; (
    input  logic                      clk,
    input  logic                      en,
    input  logic [THR_W-1:0]          thr,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic signed [NORM_W-1:0]  norm_x,
    input  logic signed [NORM_W-1:0]  norm_y,
    input  logic signed [NORM_W-1:0]  norm_z,
    output logic [LEN2_W-1:0]         len2,
    output logic signed [TU_W-1:0]    tu,
    output logic signed [TV_W-1:0]    tv
);

    localparam int PR_W  = POS_W + NORM_W;
    localparam int SUM_W = PR_W + 2;
    localparam int DN_W  = D_W + NORM_W;
    localparam int BD_W  = 2 * T_W;

    // stage 1
    logic signed [T_W-1:0]    nx_e, ny_e, nz_e;
    logic [T_W-1:0]           abs_y;
    logic                     z_seed;
    logic signed [T_W-1:0]    t_next [3];
    logic signed [PR_W-1:0]   pr_next [3];
    logic signed [POS_W-1:0]  p_s1_reg [3];
    logic signed [NORM_W-1:0] n_s1_reg [3];
    logic signed [T_W-1:0]    t_s1_reg [3];
    logic signed [PR_W-1:0]   pr_s1_reg [3];

    always_comb
    begin
        nx_e = T_W'(norm_x);
        ny_e = T_W'(norm_y);
        nz_e = T_W'(norm_z);
        abs_y = ny_e[T_W-1] ? unsigned'(-ny_e) : unsigned'(ny_e);
        z_seed = abs_y > T_W'(thr);
        if (z_seed)
        begin
            t_next[0] = ny_e;
            t_next[1] = -nx_e;
            t_next[2] = '0;
        end
        else
        begin
            t_next[0] = -nz_e;
            t_next[1] = '0;
            t_next[2] = nx_e;
        end
        pr_next[0] = PR_W'(pos_x * norm_x);
        pr_next[1] = PR_W'(pos_y * norm_y);
        pr_next[2] = PR_W'(pos_z * norm_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_s1_reg[0] <= pos_x;
            p_s1_reg[1] <= pos_y;
            p_s1_reg[2] <= pos_z;
            n_s1_reg[0] <= norm_x;
            n_s1_reg[1] <= norm_y;
            n_s1_reg[2] <= norm_z;
            for (int i = 0; i < 3; i++)
            begin
                t_s1_reg[i]  <= t_next[i];
                pr_s1_reg[i] <= pr_next[i];
            end
        end
    end

    // stage 2: d = p.n, b = t x n, |t|^2
    logic signed [SUM_W-1:0]  psum;
    logic signed [BD_W-1:0]   bd [3];
    logic signed [BD_W-1:0]   sq [3];
    logic signed [D_W-1:0]    d_next;
    logic signed [B_W-1:0]    b_next [3];
    logic [LEN2_W-1:0]        len2_next;
    logic signed [D_W-1:0]    d_s2_reg;
    logic signed [POS_W-1:0]  p_s2_reg [3];
    logic signed [NORM_W-1:0] n_s2_reg [3];
    logic signed [T_W-1:0]    t_s2_reg [3];
    logic signed [B_W-1:0]    b_s2_reg [3];
    logic [LEN2_W-1:0]        len2_s2_reg;

    always_comb
    begin
        psum = SUM_W'(pr_s1_reg[0]) + SUM_W'(pr_s1_reg[1]) + SUM_W'(pr_s1_reg[2]);
        d_next = D_W'(rnd_shr14(64'(psum)));
        bd[0] = BD_W'(t_s1_reg[1] * n_s1_reg[2]) - BD_W'(t_s1_reg[2] * n_s1_reg[1]);
        bd[1] = BD_W'(t_s1_reg[2] * n_s1_reg[0]) - BD_W'(t_s1_reg[0] * n_s1_reg[2]);
        bd[2] = BD_W'(t_s1_reg[0] * n_s1_reg[1]) - BD_W'(t_s1_reg[1] * n_s1_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            b_next[i] = B_W'(rnd_shr14(64'(bd[i])));
            sq[i] = BD_W'(t_s1_reg[i] * t_s1_reg[i]);
        end
        len2_next = LEN2_W'(sq[0] + sq[1] + sq[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_s2_reg    <= d_next;
            len2_s2_reg <= len2_next;
            for (int i = 0; i < 3; i++)
            begin
                p_s2_reg[i] <= p_s1_reg[i];
                n_s2_reg[i] <= n_s1_reg[i];
                t_s2_reg[i] <= t_s1_reg[i];
                b_s2_reg[i] <= b_next[i];
            end
        end
    end

    // stage 3: d * n
    logic signed [DN_W-1:0]   dn_next [3];
    logic signed [DN_W-1:0]   dn_s3_reg [3];
    logic signed [POS_W-1:0]  p_s3_reg [3];
    logic signed [T_W-1:0]    t_s3_reg [3];
    logic signed [B_W-1:0]    b_s3_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dn_next[i] = DN_W'(d_s2_reg * n_s2_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dn_s3_reg[i] <= dn_next[i];
                p_s3_reg[i]  <= p_s2_reg[i];
                t_s3_reg[i]  <= t_s2_reg[i];
                b_s3_reg[i]  <= b_s2_reg[i];
            end
        end
    end

    // stage 4: w = p - (p.n) n
    logic signed [W_W-1:0]    w_next [3];
    logic signed [W_W-1:0]    w_s4_reg [3];
    logic signed [T_W-1:0]    t_s4_reg [3];
    logic signed [B_W-1:0]    b_s4_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            w_next[i] = W_W'(p_s3_reg[i]) - W_W'(rnd_shr14(64'(dn_s3_reg[i])));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_s4_reg[i] <= w_next[i];
                t_s4_reg[i] <= t_s3_reg[i];
                b_s4_reg[i] <= b_s3_reg[i];
            end
        end
    end

    // stage 5: per-lane products
    logic signed [TU_W-1:0]   pu_next [3];
    logic signed [TV_W-1:0]   pv_next [3];
    logic signed [TU_W-1:0]   pu_s5_reg [3];
    logic signed [TV_W-1:0]   pv_s5_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pu_next[i] = TU_W'(w_s4_reg[i] * t_s4_reg[i]);
            pv_next[i] = TV_W'(w_s4_reg[i] * b_s4_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pu_s5_reg[i] <= pu_next[i];
                pv_s5_reg[i] <= pv_next[i];
            end
        end
    end

    // stage 6: sums
    logic signed [TU_W-1:0]   tu_next;
    logic signed [TV_W-1:0]   tv_next;
    logic signed [TU_W-1:0]   tu_s6_reg;
    logic signed [TV_W-1:0]   tv_s6_reg;

    assign tu_next = pu_s5_reg[0] + pu_s5_reg[1] + pu_s5_reg[2];
    assign tv_next = pv_s5_reg[0] + pv_s5_reg[1] + pv_s5_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu_s6_reg <= tu_next;
            tv_s6_reg <= tv_next;
        end
    end

    assign len2 = len2_s2_reg;
    assign tu   = tu_s6_reg;
    assign tv   = tv_s6_reg;

endmodule

`default_nettype wire

### hdl/tpuv_sqrt.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection: pipelined integer square root
// Digit-by-digit floor root of len2 << 16, SQ_STEPS root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpuv_sqrt import tpuv_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [LEN2_W-1:0] len2,
    output logic [LEN_W-1:0]  len,
    output logic              zero
);

    localparam int XW = 2 * LEN_W;
    localparam int RW = LEN_W + 4;

    logic [XW-1:0]    x_reg    [SQ_ST];
    logic [RW-1:0]    rem_reg  [SQ_ST];
    logic [LEN_W-1:0] root_reg [SQ_ST];
    logic             zero_reg [SQ_ST];

    for (genvar g = 0; g < SQ_ST; g++)
    begin : g_stg
        logic [XW-1:0]    x_in;
        logic [RW-1:0]    rem_in;
        logic [LEN_W-1:0] root_in;
        logic             zero_in;
        logic [RW-1:0]    rem_next;
        logic [RW-1:0]    trial;
        logic [LEN_W-1:0] root_next;

        if (g == 0)
        begin : g_first
            assign x_in    = XW'(len2) << SQ_SHIFT;
            assign rem_in  = '0;
            assign root_in = '0;
            assign zero_in = (len2 == '0);
        end
        else
        begin : g_rest
            assign x_in    = x_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign zero_in = zero_reg[g-1];
        end

        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            trial     = '0;
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                // bring down the next pair of radicand bits
                rem_next = {rem_next[RW-3:0], x_in[XW-1-2*(SQ_STEPS*g+i) -: 2]};
                trial = RW'({root_next, 2'b01});
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[LEN_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]    <= x_in;
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                zero_reg[g] <= zero_in;
            end
        end
    end

    assign len  = root_reg[SQ_ST-1];
    assign zero = zero_reg[SQ_ST-1];

endmodule

`default_nettype wire

### hdl/tpuv_div.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection: pipelined rounding divider
// round(num * 2^8 / len) magnitude, 32 quotient bits plus overflow flag.
// One prep stage, then DV_STEPS restoring steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpuv_div import tpuv_pkg::*; #(
    parameter int NUM_W = TU_W
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [LEN_W-1:0]        len,
    output logic [COORD_W-1:0]      quo,
    output logic                    neg,
    output logic                    ovf
);

    localparam int NW = NUM_W + UV_SHIFT + 1;
    localparam int QW = COORD_W;
    localparam int RW = LEN_W + 1;

    // prep: |num| << 8 plus half divisor; quotient >= 2^32 flagged up front
    logic [NUM_W-1:0] mag;
    logic [NW-1:0]    nfull;
    logic             ovf_next;
    logic [QW-1:0]    lo_p_reg;
    logic [LEN_W-1:0] r_p_reg;
    logic [LEN_W-1:0] len_p_reg;
    logic             neg_p_reg;
    logic             ovf_p_reg;

    always_comb
    begin
        mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        nfull = (NW'(mag) << UV_SHIFT) + NW'(len >> 1);
        ovf_next = nfull[NW-1:QW] >= (NW-QW)'(len);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_p_reg  <= nfull[QW-1:0];
            r_p_reg   <= nfull[QW+LEN_W-1:QW];
            len_p_reg <= len;
            neg_p_reg <= num[NUM_W-1];
            ovf_p_reg <= ovf_next;
        end
    end

    logic [QW-1:0]    lo_reg  [DV_ST];
    logic [LEN_W-1:0] r_reg   [DV_ST];
    logic [QW-1:0]    q_reg   [DV_ST];
    logic [LEN_W-1:0] len_reg [DV_ST];
    logic             neg_reg [DV_ST];
    logic             ovf_reg [DV_ST];

    for (genvar g = 0; g < DV_ST; g++)
    begin : g_stg
        logic [QW-1:0]    lo_in;
        logic [LEN_W-1:0] r_in;
        logic [QW-1:0]    q_in;
        logic [LEN_W-1:0] len_in;
        logic             neg_in;
        logic             ovf_in;
        logic [RW-1:0]    r2;
        logic [LEN_W-1:0] r_next;
        logic [QW-1:0]    q_next;

        if (g == 0)
        begin : g_first
            assign lo_in  = lo_p_reg;
            assign r_in   = r_p_reg;
            assign q_in   = '0;
            assign len_in = len_p_reg;
            assign neg_in = neg_p_reg;
            assign ovf_in = ovf_p_reg;
        end
        else
        begin : g_rest
            assign lo_in  = lo_reg[g-1];
            assign r_in   = r_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign len_in = len_reg[g-1];
            assign neg_in = neg_reg[g-1];
            assign ovf_in = ovf_reg[g-1];
        end

        always_comb
        begin
            r_next = r_in;
            q_next = q_in;
            r2     = '0;
            for (int i = 0; i < DV_STEPS; i++)
            begin
                r2 = {r_next, lo_in[QW-1-(DV_STEPS*g+i)]};
                if (r2 >= RW'(len_in))
                begin
                    r2     = r2 - RW'(len_in);
                    q_next = {q_next[QW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[QW-2:0], 1'b0};
                end
                r_next = r2[LEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[g]  <= lo_in;
                r_reg[g]   <= r_next;
                q_reg[g]   <= q_next;
                len_reg[g] <= len_in;
                neg_reg[g] <= neg_in;
                ovf_reg[g] <= ovf_in;
            end
        end
    end

    assign quo = q_reg[DV_ST-1];
    assign neg = neg_reg[DV_ST-1];
    assign ovf = ovf_reg[DV_ST-1];

endmodule

`default_nettype wire

### hdl/tangent_plane_uv_projection.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection
// Throughput: one vertex per cycle; the whole pipe advances together and
// freezes while the result register is full and stalled.
// Depth is set by the 8-stage square root (3 bits/stage) feeding the
// 9-stage dividers (4 bits/stage).
// Reset clears valid bits and loads the threshold with 14205 (0.867).
// ----------------------------------------------------------------------------
`default_nettype none

module tangent_plane_uv_projection import tpuv_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [THR_W-1:0]          cfg_wdata,
    input  logic                      vtx_valid,
    output logic                      vtx_stall,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic signed [NORM_W-1:0]  norm_x,
    input  logic signed [NORM_W-1:0]  norm_y,
    input  logic signed [NORM_W-1:0]  norm_z,
    output logic                      uv_valid,
    input  logic                      uv_stall,
    output logic signed [COORD_W-1:0] coord_u,
    output logic signed [COORD_W-1:0] coord_v,
    output logic                      saturated,
    output logic                      degenerate
);

    logic [THR_W-1:0] thr_reg;
    logic [LAT-1:0]   vld_reg;
    logic             en;

    assign en        = !vld_reg[LAT-1] || !uv_stall;
    assign vtx_stall = !en;
    assign uv_valid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], vtx_valid};
        end
    end

    logic [LEN2_W-1:0]      len2;
    logic signed [TU_W-1:0] tu;
    logic signed [TV_W-1:0] tv;
    logic [LEN_W-1:0]       len;
    logic                   zero;

    tpuv_front u_front (
        .clk    (clk),
        .en     (en),
        .thr    (thr_reg),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .norm_x (norm_x),
        .norm_y (norm_y),
        .norm_z (norm_z),
        .len2   (len2),
        .tu     (tu),
        .tv     (tv)
    );

    tpuv_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .len2 (len2),
        .len  (len),
        .zero (zero)
    );

    // align the dot products with the root
    logic signed [TU_W-1:0] tu_dly_reg [TUV_DLY];
    logic signed [TV_W-1:0] tv_dly_reg [TUV_DLY];
    logic                   deg_dly_reg [DEG_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu_dly_reg[0]  <= tu;
            tv_dly_reg[0]  <= tv;
            deg_dly_reg[0] <= zero;
            for (int k = 1; k < TUV_DLY; k++)
            begin
                tu_dly_reg[k] <= tu_dly_reg[k-1];
                tv_dly_reg[k] <= tv_dly_reg[k-1];
            end
            for (int k = 1; k < DEG_DLY; k++)
                deg_dly_reg[k] <= deg_dly_reg[k-1];
        end
    end

    logic [COORD_W-1:0] qu, qv;
    logic               neg_u, neg_v, ovf_u, ovf_v;

    tpuv_div #(.NUM_W(TU_W)) u_div_u (
        .clk (clk),
        .en  (en),
        .num (tu_dly_reg[TUV_DLY-1]),
        .len (len),
        .quo (qu),
        .neg (neg_u),
        .ovf (ovf_u)
    );

    tpuv_div #(.NUM_W(TV_W)) u_div_v (
        .clk (clk),
        .en  (en),
        .num (tv_dly_reg[TUV_DLY-1]),
        .len (len),
        .quo (qv),
        .neg (neg_v),
        .ovf (ovf_v)
    );

    localparam logic [COORD_W-1:0] MIN_VAL = COORD_W'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] MAX_VAL = ~MIN_VAL;

    function automatic clip_t clip_q(input logic [COORD_W-1:0] q,
                                     input logic neg, input logic ovf);
        clip_t r;
        if (ovf || (!neg && q[COORD_W-1]) || (neg && q > MIN_VAL))
        begin
            r.sat = 1'b1;
            r.val = neg ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = neg ? -q : q;
        end
        return r;
    endfunction

    clip_t              cu, cv;
    logic [COORD_W-1:0] u_next, v_next;
    logic               sat_next;
    logic               deg_next;
    logic [COORD_W-1:0] u_reg, v_reg;
    logic               sat_reg, deg_reg;

    always_comb
    begin
        cu = clip_q(qu, neg_u, ovf_u);
        cv = clip_q(qv, neg_v, ovf_v);
        deg_next = deg_dly_reg[DEG_DLY-1];
        if (deg_next)
        begin
            u_next   = '0;
            v_next   = '0;
            sat_next = 1'b0;
        end
        else
        begin
            u_next   = cu.val;
            v_next   = cv.val;
            sat_next = cu.sat | cv.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            sat_reg <= sat_next;
            deg_reg <= deg_next;
        end
    end

    assign coord_u    = signed'(u_reg);
    assign coord_v    = signed'(v_reg);
    assign saturated  = sat_reg;
    assign degenerate = deg_reg;

endmodule

`default_nettype wire

### hdl/tpuv_checker.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection: port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tangent_plane_uv_projection_assert.svh"

module tpuv_checker import tpuv_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      vtx_stall,
    input logic                      uv_valid,
    input logic                      uv_stall,
    input logic signed [COORD_W-1:0] coord_u,
    input logic signed [COORD_W-1:0] coord_v,
    input logic                      saturated,
    input logic                      degenerate
);

    `TPUV_ASSERT_IMP(a_deg_zero, clk, rst_n, uv_valid && degenerate, coord_u == 0 && coord_v == 0 && !saturated)
    `TPUV_ASSERT_IMP(a_sat_rail, clk, rst_n, uv_valid && saturated, coord_u == 32'sh7fffffff || coord_u == 32'sh80000000 || coord_v == 32'sh7fffffff || coord_v == 32'sh80000000)
    `TPUV_ASSERT_IMP(a_stall_cause, clk, rst_n, vtx_stall, uv_valid && uv_stall)
    `TPUV_ASSERT_NXT(a_out_hold, clk, rst_n, uv_valid && uv_stall, uv_valid && $stable(coord_u) && $stable(coord_v))

endmodule

bind tangent_plane_uv_projection tpuv_checker u_tpuv_checker (.*);

`default_nettype wire

### bench/tangent_plane_uv_projection_tb.sv
// ----------------------------------------------------------------------------
// Tangent plane UV projection testbench
// Drives vertices with random gaps and output stalls. A scoreboard predicts
// u, v and the flags from each accepted vertex and checks results in order.
// The threshold is changed between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tangent_plane_uv_projection_tb import tpuv_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               sat;
        logic               deg;
    } uv_res_t;

    class uv_scoreboard;
        uv_res_t    pending[$];
        logic [THR_W-1:0] thr;
        int         errors;

        function new();
            thr = THR_RESET;
            errors = 0;
        endfunction

        static function longint rshr14(longint x);
            if (x >= 0)
                return (x + 64'sd8192) >>> 14;
            return -((-x + 64'sd8192) >>> 14);
        endfunction

        static function longint isqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > x)
                bt >>= 2;
            while (bt != 0)
            begin
                if (x >= r + bt)
                begin
                    x -= r + bt;
                    r = (r >> 1) + bt;
                end
                else
                    r >>= 1;
                bt >>= 2;
            end
            return longint'(r);
        endfunction

        // tu*256 fits in 65+ bits, so divide at 128-bit width
        static function logic signed [127:0] rdiv(logic signed [127:0] num, longint den);
            logic [127:0] mag;
            logic [127:0] q;
            mag = num < 0 ? -num : num;
            q = (mag + den / 2) / den;
            return num < 0 ? -$signed(q) : $signed(q);
        endfunction

        static function logic [COORD_W-1:0] clip(logic signed [127:0] x, ref logic sat);
            if (x > 128'sd2147483647)
            begin
                sat = 1;
                return 32'h7fffffff;
            end
            if (x < -128'sd2147483648)
            begin
                sat = 1;
                return 32'h80000000;
            end
            return x[31:0];
        endfunction

        function void note_vertex(logic signed [31:0] px, py, pz,
                                  logic signed [15:0] nx, ny, nz);
            longint p[3], n[3], t[3], b[3], w[3];
            longint d, len2, len, ay;
            logic signed [127:0] tu, tv;
            uv_res_t r;
            p[0] = px; p[1] = py; p[2] = pz;
            n[0] = nx; n[1] = ny; n[2] = nz;
            d = rshr14(p[0] * n[0] + p[1] * n[1] + p[2] * n[2]);
            for (int i = 0; i < 3; i++)
                w[i] = p[i] - rshr14(d * n[i]);
            ay = n[1] < 0 ? -n[1] : n[1];
            if (ay > longint'(thr))
            begin
                t[0] = n[1]; t[1] = -n[0]; t[2] = 0;
            end
            else
            begin
                t[0] = -n[2]; t[1] = 0; t[2] = n[0];
            end
            b[0] = rshr14(t[1] * n[2] - t[2] * n[1]);
            b[1] = rshr14(t[2] * n[0] - t[0] * n[2]);
            b[2] = rshr14(t[0] * n[1] - t[1] * n[0]);
            len2 = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
            r.sat = 0;
            if (len2 == 0)
            begin
                r.u = 0; r.v = 0; r.deg = 1;
            end
            else
            begin
                len = isqrt(longint'(len2) << 16);
                tu = 128'(w[0]) * t[0] + 128'(w[1]) * t[1] + 128'(w[2]) * t[2];
                tv = 128'(w[0]) * b[0] + 128'(w[1]) * b[1] + 128'(w[2]) * b[2];
                r.u = clip(rdiv(tu * 256, len), r.sat);
                r.v = clip(rdiv(tv * 256, len), r.sat);
                r.deg = 0;
            end
            pending.push_back(r);
        endfunction

        function void check_uv(logic [31:0] u, v, logic sat, deg);
            uv_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result u=%h v=%h", $time, u, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (u !== e.u)
            begin
                $display("%0t: coord_u expected %h actual %h", $time, e.u, u);
                errors++;
            end
            if (v !== e.v)
            begin
                $display("%0t: coord_v expected %h actual %h", $time, e.v, v);
                errors++;
            end
            if (sat !== e.sat)
            begin
                $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
                errors++;
            end
            if (deg !== e.deg)
            begin
                $display("%0t: degenerate expected %b actual %b", $time, e.deg, deg);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [THR_W-1:0] cfg_wdata = '0;
    logic vtx_valid = 0;
    logic vtx_stall;
    logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [NORM_W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic uv_valid;
    logic uv_stall = 0;
    logic signed [COORD_W-1:0] coord_u, coord_v;
    logic saturated, degenerate;

    uv_scoreboard sb = new();
    bit quiet_tail = 0;
    bit hold_long = 0;

    tangent_plane_uv_projection u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .uv_valid(uv_valid), .uv_stall(uv_stall),
        .coord_u(coord_u), .coord_v(coord_v),
        .saturated(saturated), .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && uv_valid && !uv_stall)
            sb.check_uv(coord_u, coord_v, saturated, degenerate);
        if (rst_n && vtx_valid && !vtx_stall)
            sb.note_vertex(pos_x, pos_y, pos_z, norm_x, norm_y, norm_z);
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                uv_stall <= 1;
                repeat (200) @(posedge clk);
                uv_stall <= 0;
                hold_long = 0;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 10);
                uv_stall <= 1;
                repeat (n) @(posedge clk);
                uv_stall <= 0;
                @(posedge clk);
            end
            else
            begin
                uv_stall <= 0;
                @(posedge clk);
            end
        end
    end

    task automatic send_vertex(logic [31:0] px, py, pz, logic [15:0] nx, ny, nz);
        int g;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            g = $urandom_range(1, 10);
            vtx_valid <= 0;
            repeat (g) @(posedge clk);
        end
        vtx_valid <= 1;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        norm_x <= nx; norm_y <= ny; norm_z <= nz;
        @(posedge clk);
        while (vtx_stall)
            @(posedge clk);
    endtask

    task automatic go_idle();
        vtx_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] val);
        cfg_we <= 1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.thr = val;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_norm();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32768) - 16384);
            2: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 65536 * 64) - 65536 * 32);
            default: return 32'(int'($urandom) >>> $urandom_range(0, 16));
        endcase
    endfunction

    task automatic random_block(int cnt);
        for (int i = 0; i < cnt; i++)
            send_vertex(rand_pos(), rand_pos(), rand_pos(),
                        rand_norm(), rand_norm(), rand_norm());
    endtask

    logic [14:0] thr_list[6] = '{15'd0, 15'd16384, 15'd32767, 15'd8192, 15'd11585, 15'd14205};

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: axis normals, zero normal, extremes, saturation
        send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 16'd0, 16'd16384, 16'd0);
        send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 16'd16384, 16'd0, 16'd0);
        send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 16'd0, 16'd0, 16'd16384);
        send_vertex(32'h12345678, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0);
        send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h8000, 16'h8000, 16'h8000);
        send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 16'd1, 16'd0, 16'd1);
        send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hc000, 16'd14206, 16'd0);
        send_vertex(32'hffffffff, 32'h1, 32'hffffffff, 16'd0, 16'd14205, 16'd0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'd11585, 16'd0, 16'd11585);
        send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff);
        send_vertex(32'h7fffffff, 32'h7fffffff, 32'h0, 16'd0, 16'hc001, 16'd1);
        go_idle();
        // long hold-off on the result side while vertices keep coming
        hold_long = 1;
        random_block(60);
        go_idle();
        foreach (thr_list[k])
        begin
            set_threshold(thr_list[k]);
            random_block(200);
            go_idle();
        end
        quiet_tail = 1;
        random_block(80);
        go_idle();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
